// ===== rtl/core/wpb_pkg.sv =====
// Shared types, codes and constants of the weighted path blender.
`default_nettype none

package wpb_pkg;

    localparam int MAX_POINTS_DEF = 32;

    localparam logic [1:0] OP_LOAD_OLD = 2'd0;
    localparam logic [1:0] OP_LOAD_NEW = 2'd1;
    localparam logic [1:0] OP_MERGE    = 2'd2;

    localparam logic [1:0] ST_BLENDED = 2'd0;
    localparam logic [1:0] ST_COPIED  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_DECAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULL_WEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS     = 3'd5;

    localparam logic [15:0] ALPHA_DECAY_RST    = 16'd1638;
    localparam logic [15:0] ANGLE_GAIN_RST     = 16'd9830;
    localparam logic [15:0] INERTIA_WEIGHT_RST = 16'd16384;
    localparam logic [15:0] PULL_WEIGHT_RST    = 16'd3277;
    localparam logic [31:0] STEP_LIMIT_RST     = 32'd49152;
    localparam logic [5:0]  MIN_POINTS_RST     = 6'd10;

    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic signed [23:0] PI_Q16 = 24'sd205887;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic               final_point;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [1:0]         status;
        logic               end_of_path;
    } out_word_t;

    function automatic logic [16:0] atan_q16(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd51472;
            4'd1:    v = 17'd30385;
            4'd2:    v = 17'd16055;
            4'd3:    v = 17'd8150;
            4'd4:    v = 17'd4091;
            4'd5:    v = 17'd2047;
            4'd6:    v = 17'd1024;
            4'd7:    v = 17'd512;
            4'd8:    v = 17'd256;
            4'd9:    v = 17'd128;
            4'd10:   v = 17'd64;
            4'd11:   v = 17'd32;
            4'd12:   v = 17'd16;
            4'd13:   v = 17'd8;
            4'd14:   v = 17'd4;
            4'd15:   v = 17'd2;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wpb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wpb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/weighted_path_blender.sv =====
// Top level of the weighted path blender: path stores, merge sequencer and shared datapath.
//
// Load words (old or new waypoint) are written into two path RAMs; a final mark closes
// a path. A merge word runs a sequencer over the stored points with one shared 34x34
// multiplier, a bit-serial divider and an iterative CORDIC, and the input stays not
// ready until the merge is done. A merge runs continuity checks over both stored paths
// and a nearest-point search over the old points, emits the kept or copied points, and
// per blended point runs two divisions plus, while the old path lasts, two CORDIC runs.
// Output words wait in an output register; the sequencer stalls only when a new word
// is ready and that register is still full and not being read.
`default_nettype none

module weighted_path_blender #(
    parameter int MAX_POINTS = wpb_pkg::MAX_POINTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire wpb_pkg::in_word_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output wpb_pkg::out_word_t                   out_data,
    input  wire logic                            cfg_we,
    input  wire logic [wpb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wpb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import wpb_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int NW    = (CW > 6) ? CW : 6;
    localparam int ACC_W = 52;
    localparam int CV_W  = 56;
    localparam int DC_W  = $clog2(ACC_W);

    localparam logic [5:0] S_IDLE  = 6'd0;
    localparam logic [5:0] S_LIM   = 6'd1;
    localparam logic [5:0] S_LIM2  = 6'd2;
    localparam logic [5:0] S_CRD   = 6'd3;
    localparam logic [5:0] S_CRD2  = 6'd4;
    localparam logic [5:0] S_CRD3  = 6'd5;
    localparam logic [5:0] S_CCHK  = 6'd6;
    localparam logic [5:0] S_NRD0  = 6'd7;
    localparam logic [5:0] S_NRD1  = 6'd8;
    localparam logic [5:0] S_NRD   = 6'd9;
    localparam logic [5:0] S_NRD2  = 6'd10;
    localparam logic [5:0] S_NCMP  = 6'd11;
    localparam logic [5:0] S_NDEC  = 6'd12;
    localparam logic [5:0] S_CPRD  = 6'd13;
    localparam logic [5:0] S_CP2   = 6'd14;
    localparam logic [5:0] S_CPNX  = 6'd15;
    localparam logic [5:0] S_KRD   = 6'd16;
    localparam logic [5:0] S_K2    = 6'd17;
    localparam logic [5:0] S_KNX   = 6'd18;
    localparam logic [5:0] S_AI0   = 6'd19;
    localparam logic [5:0] S_AI1   = 6'd20;
    localparam logic [5:0] S_AI2   = 6'd21;
    localparam logic [5:0] S_BINIT = 6'd22;
    localparam logic [5:0] S_BTOP  = 6'd23;
    localparam logic [5:0] S_BR1   = 6'd24;
    localparam logic [5:0] S_BR2   = 6'd25;
    localparam logic [5:0] S_BR3   = 6'd26;
    localparam logic [5:0] S_BR4   = 6'd27;
    localparam logic [5:0] S_BTH2  = 6'd28;
    localparam logic [5:0] S_BW    = 6'd29;
    localparam logic [5:0] S_BM    = 6'd30;
    localparam logic [5:0] S_BQX   = 6'd31;
    localparam logic [5:0] S_BQY   = 6'd32;
    localparam logic [5:0] S_BTHR  = 6'd33;
    localparam logic [5:0] S_BOUT  = 6'd34;
    localparam logic [5:0] S_BG0   = 6'd35;
    localparam logic [5:0] S_BG1   = 6'd36;
    localparam logic [5:0] S_BNX   = 6'd37;
    localparam logic [5:0] S_FIN   = 6'd38;
    localparam logic [5:0] S_EMIT  = 6'd39;
    localparam logic [5:0] S_SQ0   = 6'd40;
    localparam logic [5:0] S_SQ1   = 6'd41;
    localparam logic [5:0] S_SQ2   = 6'd42;
    localparam logic [5:0] S_A0    = 6'd43;
    localparam logic [5:0] S_AN    = 6'd44;
    localparam logic [5:0] S_AR    = 6'd45;
    localparam logic [5:0] S_AF    = 6'd46;
    localparam logic [5:0] S_D0    = 6'd47;
    localparam logic [5:0] S_D1    = 6'd48;

    // control and architectural state
    logic [5:0]  state_reg, state_next;
    logic [15:0] decay_reg, gain_reg, rho_reg, pull_reg;
    logic [31:0] limit_reg;
    logic [5:0]  minpts_reg;
    logic [CW-1:0] old_cnt_reg, old_cnt_next, new_cnt_reg, new_cnt_next;
    logic old_done_reg, old_done_next, new_done_reg, new_done_next;
    logic [14:0] alpha_reg, alpha_next;
    logic signed [31:0] fb_reg, fb_next;
    logic signed [15:0] prev_reg, prev_next;
    logic [63:0] last0_reg, last0_next, last1_reg, last1_next;
    logic out_valid_reg, out_valid_next;

    // working registers
    logic [5:0]  ret_reg, ret_next;
    out_word_t   out_data_reg, out_data_next;
    out_word_t   em_reg, em_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [AW-1:0] best_reg, best_next;
    logic sel_reg, sel_next, ok_reg, ok_next, oldmode_reg, oldmode_next;
    logic havep_reg, havep_next, axis_reg, axis_next;
    logic [63:0] lim2_reg, lim2_next, bd_reg, bd_next, sq_reg, sq_next, sx_reg, sx_next;
    logic [63:0] pa_reg, pa_next, pb_reg, pb_next, nst_reg, nst_next;
    logic [63:0] nprev_reg, nprev_next, ncur_reg, ncur_next;
    logic [63:0] oprev_reg, oprev_next, ocur_reg, ocur_next;
    logic signed [15:0] th2_reg, th2_next, t1_reg, t1_next, ang_reg, ang_next;
    logic signed [15:0] cur_reg, cur_next;
    logic signed [67:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next, rx_reg, rx_next;
    logic [2:0]  k_reg, k_next;
    logic [ACC_W-1:0] mag_reg, mag_next;
    logic [17:0] rem_reg, rem_next;
    logic [DC_W-1:0] dcnt_reg, dcnt_next;
    logic dneg_reg, dneg_next;
    logic signed [CV_W-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [CV_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [CV_W-1:0] cm_reg, cm_next;
    logic signed [23:0] cz_reg, cz_next;
    logic [3:0]  ck_reg, ck_next;

    // datapath
    logic signed [33:0] mul_a, mul_b;
    logic [AW-1:0] raddr;
    logic old_we, new_we;
    logic [63:0] old_rdata, new_rdata, wdata;
    logic in_fire;
    logic [CW-1:0] cnt_sel, ip1, jp1, im1, jm1;
    logic [63:0] rd_sel;
    logic [5:0]  minp;
    logic signed [32:0] dxs, dys, adx, ady;
    logic [64:0] sqsum;
    logic signed [32:0] c1x, c1y, c2x, c2y, c3x, c3y, ivx, ivy;
    logic [14:0] w1, w2;
    logic [17:0] den;
    logic [18:0] rem2;
    logic rge;
    logic signed [ACC_W-1:0] quot;
    logic signed [33:0] a_calc;
    logic signed [17:0] dang;
    logic signed [35:0] g_raw, g_adj, g_sh;
    logic signed [52:0] sumx, sumy;
    logic signed [31:0] satx, saty;
    logic signed [CV_W-1:0] shx, shy, fx, fy, fay;
    logic signed [23:0] zr;

    function automatic logic signed [32:0] dif33(input logic [31:0] a, input logic [31:0] b);
        return $signed({a[31], a}) - $signed({b[31], b});
    endfunction

    wpb_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_old_ram (
        .clk   (clk),
        .we    (old_we),
        .waddr (old_cnt_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (old_rdata)
    );

    wpb_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_new_ram (
        .clk   (clk),
        .we    (new_we),
        .waddr (new_cnt_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (new_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign wdata     = {in_data.x_coord, in_data.y_coord};

    assign minp    = (minpts_reg < 6'd2) ? 6'd2 : minpts_reg;
    assign cnt_sel = sel_reg ? new_cnt_reg : old_cnt_reg;
    assign rd_sel  = sel_reg ? new_rdata : old_rdata;
    assign ip1     = i_reg + CW'(1);
    assign jp1     = j_reg + CW'(1);
    assign im1     = i_reg - CW'(1);
    assign jm1     = j_reg - CW'(1);

    assign dxs = dif33(pa_reg[63:32], pb_reg[63:32]);
    assign dys = dif33(pa_reg[31:0], pb_reg[31:0]);
    assign adx = dxs[32] ? -dxs : dxs;
    assign ady = dys[32] ? -dys : dys;
    assign sqsum = {1'b0, sx_reg} + {1'b0, prod_reg[63:0]};

    assign c1x = dif33(ocur_reg[63:32], oprev_reg[63:32]);
    assign c1y = dif33(ocur_reg[31:0], oprev_reg[31:0]);
    assign c2x = dif33(ncur_reg[63:32], nprev_reg[63:32]);
    assign c2y = dif33(ncur_reg[31:0], nprev_reg[31:0]);
    assign c3x = dif33(ncur_reg[63:32], last1_reg[63:32]);
    assign c3y = dif33(ncur_reg[31:0], last1_reg[31:0]);
    assign ivx = havep_reg ? dif33(last1_reg[63:32], last0_reg[63:32]) : 33'sd0;
    assign ivy = havep_reg ? dif33(last1_reg[31:0], last0_reg[31:0]) : 33'sd0;
    assign w1  = oldmode_reg ? alpha_reg : 15'd0;
    assign w2  = ONE_Q14 - w1;
    assign den = 18'd16384 + {2'b0, pull_reg} + {2'b0, rho_reg};

    assign rem2 = {rem_reg, mag_reg[ACC_W-1]};
    assign rge  = (rem2 >= {1'b0, den});
    assign quot = dneg_reg ? -$signed(mag_reg) : $signed(mag_reg);

    assign a_calc = $signed({19'b0, alpha_reg}) - $signed({18'b0, decay_reg})
                    - $signed({{2{fb_reg[31]}}, fb_reg});
    assign dang  = $signed({{2{cur_reg[15]}}, cur_reg}) - $signed({{2{prev_reg[15]}}, prev_reg});
    assign g_raw = prod_reg[35:0];
    assign g_adj = ((prev_reg < 0) || (cur_reg < 0)) ? -g_raw : g_raw;
    assign g_sh  = (g_adj + 36'sd2048) >>> 12;

    assign sumx = $signed({{21{last1_reg[63]}}, last1_reg[63:32]}) + $signed({rx_reg[ACC_W-1], rx_reg});
    assign sumy = $signed({{21{last1_reg[31]}}, last1_reg[31:0]}) + $signed({quot[ACC_W-1], quot});
    assign satx = (sumx > 53'sd2147483647) ? 32'sh7fffffff :
                  (sumx < -53'sd2147483648) ? 32'sh80000000 : sumx[31:0];
    assign saty = (sumy > 53'sd2147483647) ? 32'sh7fffffff :
                  (sumy < -53'sd2147483648) ? 32'sh80000000 : sumy[31:0];

    assign shx = cy_reg >>> ck_reg;
    assign shy = cx_reg >>> ck_reg;
    assign fx  = (vx_reg < 0) ? -vx_reg : vx_reg;
    assign fy  = (vx_reg < 0) ? -vy_reg : vy_reg;
    assign fay = (fy < 0) ? -fy : fy;
    assign zr  = (cz_reg + 24'sd8) >>> 4;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_LIM:
            begin
                mul_a = {2'b0, limit_reg};
                mul_b = {2'b0, limit_reg};
            end
            S_SQ0:
            begin
                mul_a = {adx[32], adx};
                mul_b = {adx[32], adx};
            end
            S_SQ1:
            begin
                mul_a = {ady[32], ady};
                mul_b = {ady[32], ady};
            end
            S_BM:
            begin
                case (k_reg)
                    3'd0:
                    begin
                        mul_a = axis_reg ? {c1y[32], c1y} : {c1x[32], c1x};
                        mul_b = {19'b0, w1};
                    end
                    3'd1:
                    begin
                        mul_a = axis_reg ? {c2y[32], c2y} : {c2x[32], c2x};
                        mul_b = {19'b0, w2};
                    end
                    3'd2:
                    begin
                        mul_a = axis_reg ? {c3y[32], c3y} : {c3x[32], c3x};
                        mul_b = {18'b0, pull_reg};
                    end
                    3'd3:
                    begin
                        mul_a = axis_reg ? {ivy[32], ivy} : {ivx[32], ivx};
                        mul_b = {18'b0, rho_reg};
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_BG0:
            begin
                mul_a = {{16{dang[17]}}, dang};
                mul_b = {18'b0, gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        old_cnt_next   = old_cnt_reg;
        new_cnt_next   = new_cnt_reg;
        old_done_next  = old_done_reg;
        new_done_next  = new_done_reg;
        alpha_next     = alpha_reg;
        fb_next        = fb_reg;
        prev_next      = prev_reg;
        last0_next     = last0_reg;
        last1_next     = last1_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ret_next       = ret_reg;
        em_next        = em_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        best_next      = best_reg;
        sel_next       = sel_reg;
        ok_next        = ok_reg;
        oldmode_next   = oldmode_reg;
        havep_next     = havep_reg;
        axis_next      = axis_reg;
        lim2_next      = lim2_reg;
        bd_next        = bd_reg;
        sq_next        = sq_reg;
        sx_next        = sx_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        nst_next       = nst_reg;
        nprev_next     = nprev_reg;
        ncur_next      = ncur_reg;
        oprev_next     = oprev_reg;
        ocur_next      = ocur_reg;
        th2_next       = th2_reg;
        t1_next        = t1_reg;
        ang_next       = ang_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        rx_next        = rx_reg;
        k_next         = k_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        dneg_next      = dneg_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cm_next        = cm_reg;
        cz_next        = cz_reg;
        ck_next        = ck_reg;
        raddr          = '0;
        old_we         = 1'b0;
        new_we         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_data.operation)
                        OP_LOAD_OLD:
                        begin
                            if (!old_done_reg)
                            begin
                                if (old_cnt_reg < CW'(MAX_POINTS))
                                begin
                                    old_we       = 1'b1;
                                    old_cnt_next = old_cnt_reg + CW'(1);
                                end
                                if (in_data.final_point)
                                begin
                                    old_done_next = 1'b1;
                                end
                            end
                        end
                        OP_LOAD_NEW:
                        begin
                            if (!new_done_reg)
                            begin
                                if (new_cnt_reg < CW'(MAX_POINTS))
                                begin
                                    new_we       = 1'b1;
                                    new_cnt_next = new_cnt_reg + CW'(1);
                                end
                                if (in_data.final_point)
                                begin
                                    new_done_next = 1'b1;
                                end
                            end
                        end
                        OP_MERGE:
                        begin
                            if (old_done_reg && new_done_reg)
                            begin
                                ok_next    = 1'b0;
                                state_next = S_LIM;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LIM:
            begin
                state_next = S_LIM2;
            end
            S_LIM2:
            begin
                lim2_next = prod_reg[63:0];
                if ((NW'(old_cnt_reg) < NW'(minp)) || (NW'(new_cnt_reg) < NW'(minp)))
                begin
                    em_next    = '{32'sd0, 32'sd0, ST_INVALID, 1'b1};
                    ret_next   = S_FIN;
                    state_next = S_EMIT;
                end
                else
                begin
                    sel_next   = 1'b0;
                    i_next     = CW'(1);
                    state_next = S_CRD;
                end
            end
            S_CRD:
            begin
                raddr      = im1[AW-1:0];
                state_next = S_CRD2;
            end
            S_CRD2:
            begin
                pa_next    = rd_sel;
                raddr      = i_reg[AW-1:0];
                state_next = S_CRD3;
            end
            S_CRD3:
            begin
                pb_next    = rd_sel;
                ret_next   = S_CCHK;
                state_next = S_SQ0;
            end
            S_CCHK:
            begin
                if (sq_reg >= lim2_reg)
                begin
                    em_next    = '{32'sd0, 32'sd0, ST_INVALID, 1'b1};
                    ret_next   = S_FIN;
                    state_next = S_EMIT;
                end
                else if (ip1 < cnt_sel)
                begin
                    i_next     = ip1;
                    state_next = S_CRD;
                end
                else if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    i_next     = CW'(1);
                    state_next = S_CRD;
                end
                else
                begin
                    state_next = S_NRD0;
                end
            end
            S_NRD0:
            begin
                state_next = S_NRD1;
            end
            S_NRD1:
            begin
                nst_next   = new_rdata;
                i_next     = '0;
                bd_next    = '1;
                best_next  = '0;
                state_next = S_NRD;
            end
            S_NRD:
            begin
                raddr      = i_reg[AW-1:0];
                state_next = S_NRD2;
            end
            S_NRD2:
            begin
                pa_next    = old_rdata;
                pb_next    = nst_reg;
                ret_next   = S_NCMP;
                state_next = S_SQ0;
            end
            S_NCMP:
            begin
                if (sq_reg < bd_reg)
                begin
                    bd_next   = sq_reg;
                    best_next = i_reg[AW-1:0];
                end
                if (ip1 < old_cnt_reg)
                begin
                    i_next     = ip1;
                    state_next = S_NRD;
                end
                else
                begin
                    state_next = S_NDEC;
                end
            end
            S_NDEC:
            begin
                ok_next = 1'b1;
                i_next  = '0;
                j_next  = '0;
                if (bd_reg >= lim2_reg)
                begin
                    state_next = S_CPRD;
                end
                else
                begin
                    state_next = S_KRD;
                end
            end
            S_CPRD:
            begin
                raddr      = j_reg[AW-1:0];
                state_next = S_CP2;
            end
            S_CP2:
            begin
                em_next    = '{$signed(new_rdata[63:32]), $signed(new_rdata[31:0]),
                               ST_COPIED, (jp1 == new_cnt_reg)};
                ret_next   = S_CPNX;
                state_next = S_EMIT;
            end
            S_CPNX:
            begin
                if (jp1 < new_cnt_reg)
                begin
                    j_next     = jp1;
                    state_next = S_CPRD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_KRD:
            begin
                raddr      = i_reg[AW-1:0];
                state_next = S_K2;
            end
            S_K2:
            begin
                em_next    = '{$signed(old_rdata[63:32]), $signed(old_rdata[31:0]),
                               ST_BLENDED, 1'b0};
                last0_next = last1_reg;
                last1_next = old_rdata;
                ret_next   = S_KNX;
                state_next = S_EMIT;
            end
            S_KNX:
            begin
                if (i_reg == CW'(best_reg))
                begin
                    state_next = S_AI0;
                end
                else
                begin
                    i_next     = ip1;
                    state_next = S_KRD;
                end
            end
            S_AI0:
            begin
                if (best_reg == '0)
                begin
                    prev_next  = '0;
                    state_next = S_BINIT;
                end
                else
                begin
                    vx_next    = CV_W'(dif33(last1_reg[63:32], last0_reg[63:32]));
                    vy_next    = CV_W'(dif33(last1_reg[31:0], last0_reg[31:0]));
                    ret_next   = S_AI1;
                    state_next = S_A0;
                end
            end
            S_AI1:
            begin
                t1_next    = ang_reg;
                vx_next    = CV_W'(dif33(nst_reg[63:32], last0_reg[63:32]));
                vy_next    = CV_W'(dif33(nst_reg[31:0], last0_reg[31:0]));
                ret_next   = S_AI2;
                state_next = S_A0;
            end
            S_AI2:
            begin
                prev_next  = ang_reg - t1_reg;
                state_next = S_BINIT;
            end
            S_BINIT:
            begin
                j_next     = CW'(1);
                i_next     = CW'(best_reg) + CW'(1);
                havep_next = (best_reg != '0);
                state_next = S_BTOP;
            end
            S_BTOP:
            begin
                if (j_reg >= new_cnt_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    oldmode_next = (i_reg < old_cnt_reg);
                    raddr        = jm1[AW-1:0];
                    state_next   = S_BR1;
                end
            end
            S_BR1:
            begin
                nprev_next = new_rdata;
                raddr      = j_reg[AW-1:0];
                state_next = S_BR2;
            end
            S_BR2:
            begin
                ncur_next  = new_rdata;
                raddr      = im1[AW-1:0];
                state_next = S_BR3;
            end
            S_BR3:
            begin
                oprev_next = old_rdata;
                raddr      = i_reg[AW-1:0];
                state_next = S_BR4;
            end
            S_BR4:
            begin
                ocur_next = old_rdata;
                if (oldmode_reg)
                begin
                    vx_next    = CV_W'(c2x);
                    vy_next    = CV_W'(c2y);
                    ret_next   = S_BTH2;
                    state_next = S_A0;
                end
                else
                begin
                    state_next = S_BW;
                end
            end
            S_BTH2:
            begin
                th2_next = ang_reg;
                if (alpha_reg != '0)
                begin
                    if (a_calc > 34'sd16384)
                    begin
                        alpha_next = ONE_Q14;
                    end
                    else if (a_calc < 34'sd0)
                    begin
                        alpha_next = '0;
                    end
                    else
                    begin
                        alpha_next = a_calc[14:0];
                    end
                end
                state_next = S_BW;
            end
            S_BW:
            begin
                axis_next  = 1'b0;
                k_next     = '0;
                acc_next   = '0;
                state_next = S_BM;
            end
            S_BM:
            begin
                if (k_reg != 3'd0)
                begin
                    acc_next = acc_reg + prod_reg[ACC_W-1:0];
                end
                if (k_reg == 3'd4)
                begin
                    ret_next   = axis_reg ? S_BQY : S_BQX;
                    state_next = S_D0;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            S_BQX:
            begin
                rx_next    = quot;
                axis_next  = 1'b1;
                k_next     = '0;
                acc_next   = '0;
                state_next = S_BM;
            end
            S_BQY:
            begin
                em_next    = '{satx, saty, ST_BLENDED, (jp1 == new_cnt_reg)};
                if (oldmode_reg)
                begin
                    vx_next    = CV_W'(rx_reg);
                    vy_next    = CV_W'(quot);
                    ret_next   = S_BTHR;
                    state_next = S_A0;
                end
                else
                begin
                    state_next = S_BOUT;
                end
            end
            S_BTHR:
            begin
                cur_next   = th2_reg - ang_reg;
                state_next = S_BOUT;
            end
            S_BOUT:
            begin
                last0_next = last1_reg;
                last1_next = {em_reg.out_x, em_reg.out_y};
                havep_next = 1'b1;
                ret_next   = oldmode_reg ? S_BG0 : S_BNX;
                state_next = S_EMIT;
            end
            S_BG0:
            begin
                state_next = S_BG1;
            end
            S_BG1:
            begin
                fb_next    = g_sh[31:0];
                prev_next  = cur_reg;
                state_next = S_BNX;
            end
            S_BNX:
            begin
                j_next = jp1;
                if (oldmode_reg)
                begin
                    i_next = ip1;
                end
                state_next = S_BTOP;
            end
            S_FIN:
            begin
                old_cnt_next  = '0;
                new_cnt_next  = '0;
                old_done_next = 1'b0;
                new_done_next = 1'b0;
                if (ok_reg)
                begin
                    alpha_next = ONE_Q14;
                end
                state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = em_reg;
                    state_next     = ret_reg;
                end
            end
            S_SQ0:
            begin
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                sx_next    = prod_reg[63:0];
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                sq_next    = sqsum[64] ? '1 : sqsum[63:0];
                state_next = ret_reg;
            end
            S_A0:
            begin
                if ((vx_reg == '0) && (vy_reg == '0))
                begin
                    ang_next   = '0;
                    state_next = ret_reg;
                end
                else
                begin
                    cx_next = fx;
                    cy_next = fy;
                    cm_next = (fx > fay) ? fx : fay;
                    if (vx_reg < 0)
                    begin
                        cz_next = (vy_reg >= 0) ? PI_Q16 : -PI_Q16;
                    end
                    else
                    begin
                        cz_next = '0;
                    end
                    state_next = S_AN;
                end
            end
            S_AN:
            begin
                if (cm_reg >= CV_W'(64'h8000_0000))
                begin
                    cx_next = cx_reg >>> 1;
                    cy_next = cy_reg >>> 1;
                    cm_next = cm_reg >> 1;
                end
                else if (cm_reg < CV_W'(64'h4000_0000))
                begin
                    cx_next = cx_reg <<< 1;
                    cy_next = cy_reg <<< 1;
                    cm_next = cm_reg << 1;
                end
                else
                begin
                    ck_next    = '0;
                    state_next = S_AR;
                end
            end
            S_AR:
            begin
                if (cy_reg >= 0)
                begin
                    cx_next = cx_reg + shx;
                    cy_next = cy_reg - shy;
                    cz_next = cz_reg + $signed({7'b0, atan_q16(ck_reg)});
                end
                else
                begin
                    cx_next = cx_reg - shx;
                    cy_next = cy_reg + shy;
                    cz_next = cz_reg - $signed({7'b0, atan_q16(ck_reg)});
                end
                ck_next = ck_reg + 4'd1;
                if (ck_reg == 4'd15)
                begin
                    state_next = S_AF;
                end
            end
            S_AF:
            begin
                ang_next   = zr[15:0];
                state_next = ret_reg;
            end
            S_D0:
            begin
                dneg_next  = acc_reg[ACC_W-1];
                mag_next   = acc_reg[ACC_W-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = S_D1;
            end
            S_D1:
            begin
                rem_next  = rge ? 18'(rem2 - {1'b0, den}) : rem2[17:0];
                mag_next  = {mag_reg[ACC_W-2:0], rge};
                dcnt_next = dcnt_reg + DC_W'(1);
                if (dcnt_reg == DC_W'(ACC_W - 1))
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            decay_reg     <= ALPHA_DECAY_RST;
            gain_reg      <= ANGLE_GAIN_RST;
            rho_reg       <= INERTIA_WEIGHT_RST;
            pull_reg      <= PULL_WEIGHT_RST;
            limit_reg     <= STEP_LIMIT_RST;
            minpts_reg    <= MIN_POINTS_RST;
            old_cnt_reg   <= '0;
            new_cnt_reg   <= '0;
            old_done_reg  <= 1'b0;
            new_done_reg  <= 1'b0;
            alpha_reg     <= ONE_Q14;
            fb_reg        <= '0;
            prev_reg      <= '0;
            last0_reg     <= '0;
            last1_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            old_cnt_reg   <= old_cnt_next;
            new_cnt_reg   <= new_cnt_next;
            old_done_reg  <= old_done_next;
            new_done_reg  <= new_done_next;
            alpha_reg     <= alpha_next;
            fb_reg        <= fb_next;
            prev_reg      <= prev_next;
            last0_reg     <= last0_next;
            last1_reg     <= last1_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALPHA_DECAY:    decay_reg  <= cfg_data[15:0];
                    REG_ANGLE_GAIN:     gain_reg   <= cfg_data[15:0];
                    REG_INERTIA_WEIGHT: rho_reg    <= cfg_data[15:0];
                    REG_PULL_WEIGHT:    pull_reg   <= cfg_data[15:0];
                    REG_STEP_LIMIT:     limit_reg  <= cfg_data[31:0];
                    REG_MIN_POINTS:     minpts_reg <= cfg_data[5:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        ret_reg      <= ret_next;
        em_reg       <= em_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        best_reg     <= best_next;
        sel_reg      <= sel_next;
        ok_reg       <= ok_next;
        oldmode_reg  <= oldmode_next;
        havep_reg    <= havep_next;
        axis_reg     <= axis_next;
        lim2_reg     <= lim2_next;
        bd_reg       <= bd_next;
        sq_reg       <= sq_next;
        sx_reg       <= sx_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        nst_reg      <= nst_next;
        nprev_reg    <= nprev_next;
        ncur_reg     <= ncur_next;
        oprev_reg    <= oprev_next;
        ocur_reg     <= ocur_next;
        th2_reg      <= th2_next;
        t1_reg       <= t1_next;
        ang_reg      <= ang_next;
        cur_reg      <= cur_next;
        prod_reg     <= mul_a * mul_b;
        acc_reg      <= acc_next;
        rx_reg       <= rx_next;
        k_reg        <= k_next;
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        dneg_reg     <= dneg_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cm_reg       <= cm_next;
        cz_reg       <= cz_next;
        ck_reg       <= ck_next;
    end

endmodule

`default_nettype wire
